@@ rtl/esc_pkg.sv @@
package esc_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    localparam int CFG_W       = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // fixed result field widths
    localparam int VPAGE_W    = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int M_W        = 24;

    // flags carried by the scan token from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
        logic bc_found;   // slot with reference and modify both clear
        logic cl_found;   // slot with modify clear
    } scan_flags_t;

    // update broadcast to every cell at the end of a lookup
    typedef struct packed {
        logic en;
        logic hit;
        logic fill;
        logic repl;
        logic bc_found;
    } apply_t;

endpackage

@@ rtl/enhanced_second_chance_replacer.sv @@
// Enhanced second chance page replacer. Each input transaction is one page
// reference (page number and a write flag); each one yields exactly one result
// transaction with hit, the slot now holding the page, whether a page was
// evicted, and the evicted page and its modify bit. The frame table lives in a
// row of FRAMES cells, each holding one slot's page, reference bit and modify
// bit. A lookup sends a token down the row, one cell per cycle, collecting the
// hit slot and the replacement candidates; the decision is then broadcast to
// all cells together. A reference occupies the block from acceptance until the
// token has walked the cell row and the decision is applied, so only one is in
// flight at a time; a stalled result port adds its stall.
// The result sits in an output register, so the block is ready for the next
// reference while the previous result is still waiting. frames_in_use limits
// how many slots fill before replacement starts (0 acts as 1, values above
// FRAMES act as FRAMES); write it only while no reference is in flight.
module enhanced_second_chance_replacer
    import esc_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    localparam int S_W      = ((PAGE_BITS + 1 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // reference input
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [S_W-1:0]   s_tdata,   // page [PAGE_BITS-1:0], write, zero pad
    // result output
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [M_W-1:0]   m_tdata,   // hit, slot[4], replaced, victim_page[16],
                                        // victim_dirty, zero pad
    // frames_in_use register
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DONE
    } state_t;

    state_t               state_reg;
    logic [CFG_W-1:0]     cfg_reg;
    logic [CNT_W-1:0]     filled_reg;
    logic [CNT_W-1:0]     limit;
    logic                 launch_reg;

    // request held for the whole lookup, seen by every cell
    logic [PAGE_BITS-1:0] req_page_reg;
    logic                 req_write_reg;

    // token chain between cells
    scan_flags_t          tok  [FRAMES+1];
    logic [SLOT_W-1:0]    hs   [FRAMES+1];
    logic [SLOT_W-1:0]    bcs  [FRAMES+1];
    logic [PAGE_BITS-1:0] bcp  [FRAMES+1];
    logic [SLOT_W-1:0]    cls  [FRAMES+1];
    logic [PAGE_BITS-1:0] clp  [FRAMES+1];

    // token captured at the end of the row
    scan_flags_t          res_flags_reg;
    logic [SLOT_W-1:0]    res_hs_reg, res_bcs_reg, res_cls_reg;
    logic [PAGE_BITS-1:0] res_bcp_reg, res_clp_reg;

    logic                 m_tvalid_reg;
    logic [M_W-1:0]       m_tdata_reg;

    apply_t               apply;
    logic [SLOT_W-1:0]    target;
    logic                 out_free, do_fill, do_repl, vdirty;
    logic [PAGE_BITS-1:0] vpage;
    logic [VPAGE_W+PAGE_BITS-1:0] vpage_ext;
    logic [SLOT_OUT_W+SLOT_W-1:0] slot_ext;
    logic                 s_accept;

    // saturate the register into the usable range
    always_comb begin
        if (cfg_reg == '0) begin
            limit = CNT_W'(1);
        end else if (32'(cfg_reg) > 32'(FRAMES)) begin
            limit = CNT_W'(FRAMES);
        end else begin
            limit = CNT_W'(cfg_reg);
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // token enters cell 0 empty, in the cycle after the request is taken
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = launch_reg;
        hs[0]        = '0;
        bcs[0]       = '0;
        bcp[0]       = '0;
        cls[0]       = '0;
        clp[0]       = '0;
    end

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            esc_cell #(
                .IDX       (g),
                .PAGE_BITS (PAGE_BITS),
                .SLOT_W    (SLOT_W),
                .CNT_W     (CNT_W)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .req_page     (req_page_reg),
                .req_write    (req_write_reg),
                .filled       (filled_reg),
                .limit        (limit),
                .apply        (apply),
                .apply_slot   (target),
                .tok_in       (tok[g]),
                .hit_slot_in  (hs[g]),
                .bc_slot_in   (bcs[g]),
                .bc_page_in   (bcp[g]),
                .cl_slot_in   (cls[g]),
                .cl_page_in   (clp[g]),
                .tok_out      (tok[g+1]),
                .hit_slot_out (hs[g+1]),
                .bc_slot_out  (bcs[g+1]),
                .bc_page_out  (bcp[g+1]),
                .cl_slot_out  (cls[g+1]),
                .cl_page_out  (clp[g+1])
            );
        end
    endgenerate

    // decision from the captured token
    always_comb begin
        do_fill = !res_flags_reg.hit && (filled_reg < limit);
        do_repl = !res_flags_reg.hit && !(filled_reg < limit);
        if (res_flags_reg.hit) begin
            target = res_hs_reg;
        end else if (do_fill) begin
            target = filled_reg[SLOT_W-1:0];
        end else if (res_flags_reg.bc_found) begin
            target = res_bcs_reg;
        end else begin
            // first clean slot, or slot 0 when every slot is modified
            target = res_cls_reg;
        end
        vpage  = '0;
        vdirty = 1'b0;
        if (do_repl) begin
            vpage  = res_flags_reg.bc_found ? res_bcp_reg : res_clp_reg;
            vdirty = !res_flags_reg.bc_found && !res_flags_reg.cl_found;
        end
        apply.en       = (state_reg == DONE) && out_free;
        apply.hit      = res_flags_reg.hit;
        apply.fill     = do_fill;
        apply.repl     = do_repl;
        apply.bc_found = res_flags_reg.bc_found;
        vpage_ext      = {{VPAGE_W{1'b0}}, vpage};
        slot_ext       = {{SLOT_OUT_W{1'b0}}, target};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            cfg_reg      <= CFG_RESET;
            filled_reg   <= '0;
            launch_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            launch_reg <= s_accept;
            // a new result replacing the one just taken keeps valid high
            if (m_tvalid_reg && m_tready && !apply.en) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_accept) begin
                        state_reg <= SCAN;
                    end
                end
                SCAN: begin
                    if (tok[FRAMES].valid) begin
                        state_reg <= DONE;
                    end
                end
                DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (do_fill) begin
                            filled_reg <= filled_reg + CNT_W'(1);
                        end
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_page_reg  <= s_tdata[PAGE_BITS-1:0];
            req_write_reg <= s_tdata[PAGE_BITS];
        end
        if (state_reg == SCAN && tok[FRAMES].valid) begin
            res_flags_reg <= tok[FRAMES];
            res_hs_reg    <= hs[FRAMES];
            res_bcs_reg   <= bcs[FRAMES];
            res_bcp_reg   <= bcp[FRAMES];
            res_cls_reg   <= cls[FRAMES];
            res_clp_reg   <= clp[FRAMES];
        end
        if (apply.en) begin
            m_tdata_reg <= {1'b0, vdirty, vpage_ext[VPAGE_W-1:0], do_repl,
                            slot_ext[SLOT_OUT_W-1:0], res_flags_reg.hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/esc_cell.sv @@
module esc_cell
    import esc_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int SLOT_W    = 4,
    parameter int CNT_W     = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [PAGE_BITS-1:0] req_page,
    input  logic                 req_write,
    input  logic [CNT_W-1:0]     filled,
    input  logic [CNT_W-1:0]     limit,
    input  apply_t               apply,
    input  logic [SLOT_W-1:0]    apply_slot,
    input  scan_flags_t          tok_in,
    input  logic [SLOT_W-1:0]    hit_slot_in,
    input  logic [SLOT_W-1:0]    bc_slot_in,
    input  logic [PAGE_BITS-1:0] bc_page_in,
    input  logic [SLOT_W-1:0]    cl_slot_in,
    input  logic [PAGE_BITS-1:0] cl_page_in,
    output scan_flags_t          tok_out,
    output logic [SLOT_W-1:0]    hit_slot_out,
    output logic [SLOT_W-1:0]    bc_slot_out,
    output logic [PAGE_BITS-1:0] bc_page_out,
    output logic [SLOT_W-1:0]    cl_slot_out,
    output logic [PAGE_BITS-1:0] cl_page_out
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);
    localparam logic [CNT_W-1:0]  MY_CNT  = CNT_W'(IDX);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 ref_reg;
    logic                 dirty_reg;

    scan_flags_t          tok_reg, tok_next;
    logic [SLOT_W-1:0]    hs_reg, hs_next, bcs_reg, bcs_next, cls_reg, cls_next;
    logic [PAGE_BITS-1:0] bcp_reg, bcp_next, clp_reg, clp_next;

    logic occupied, in_range, is_me;

    assign occupied = MY_CNT < filled;
    assign in_range = MY_CNT < limit;
    assign is_me    = apply_slot == MY_SLOT;

    always_comb begin
        tok_next = tok_in;
        hs_next  = hit_slot_in;
        bcs_next = bc_slot_in;
        bcp_next = bc_page_in;
        cls_next = cl_slot_in;
        clp_next = cl_page_in;
        if (occupied && (page_reg == req_page) && !tok_in.hit) begin
            tok_next.hit = 1'b1;
            hs_next      = MY_SLOT;
        end
        if (in_range && !ref_reg && !dirty_reg && !tok_in.bc_found) begin
            tok_next.bc_found = 1'b1;
            bcs_next          = MY_SLOT;
            bcp_next          = page_reg;
        end
        // slot 0 is the fallback victim when every slot is modified
        if (IDX == 0) begin
            clp_next = page_reg;
        end
        if (in_range && !dirty_reg && !tok_in.cl_found) begin
            tok_next.cl_found = 1'b1;
            cls_next          = MY_SLOT;
            clp_next          = page_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            ref_reg   <= 1'b0;
            dirty_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (apply.en) begin
                if (is_me) begin
                    if (apply.hit) begin
                        ref_reg   <= 1'b1;
                        dirty_reg <= dirty_reg | req_write;
                    end else if (apply.fill || apply.repl) begin
                        ref_reg   <= 1'b1;
                        dirty_reg <= req_write;
                    end
                end else if (apply.repl && in_range &&
                             (!apply.bc_found || (MY_SLOT < apply_slot))) begin
                    ref_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        hs_reg  <= hs_next;
        bcs_reg <= bcs_next;
        bcp_reg <= bcp_next;
        cls_reg <= cls_next;
        clp_reg <= clp_next;
        if (apply.en && is_me && !apply.hit && (apply.fill || apply.repl)) begin
            page_reg <= req_page;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_slot_out = hs_reg;
    assign bc_slot_out  = bcs_reg;
    assign bc_page_out  = bcp_reg;
    assign cl_slot_out  = cls_reg;
    assign cl_page_out  = clp_reg;

endmodule

@@ rtl/esc_checker.sv @@
module esc_checker
    import esc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [M_W-1:0]   m_tdata
);

    // ready for a reference right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_tready)
        else $error("not ready after reset");

    // one reference at a time: taking one drops ready
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("second reference taken or result too early");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[5] && !m_tdata[22] &&
                                   (m_tdata[21:6] == '0))
        else $error("hit result reports an eviction");

    // stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind enhanced_second_chance_replacer esc_checker u_esc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
);
